>>> hw/rtl/bgtm_pkg.sv
// Shared types, constants and curve tables for the battery gauge.
package bgtm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLES_PER_READING_DEF = 5;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int OHM_W = 20;
    localparam int MV_W = 16;
    localparam int PCT_W = 7;
    localparam int SUMS_W = OHM_W + 1;
    localparam int DIV_W = SAMPLE_BITS + SUMS_W;
    localparam int NBITS_W = $clog2(DIV_W + 1);
    localparam int CURVE_X_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PINS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 3'd7;

    localparam logic [1:0] OUT_NEW      = 2'd0;
    localparam logic [1:0] OUT_HELD     = 2'd1;
    localparam logic [1:0] OUT_NONE     = 2'd2;
    localparam logic [1:0] OUT_FAILED   = 2'd3;

    localparam logic [MV_W-1:0] CURVE_MV [9] = '{
        16'd3300, 16'd3450, 16'd3600, 16'd3700, 16'd3800,
        16'd3900, 16'd4000, 16'd4100, 16'd4200
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [9] = '{
        7'd0, 7'd5, 7'd15, 7'd30, 7'd50, 7'd65, 7'd80, 7'd92, 7'd100
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_millivolts;
        logic                   sample_failed;
        logic                   charge_pin_level;
        logic                   full_pin_level;
    } t_bg_in;

    typedef struct packed {
        logic             has_reading;
        logic [1:0]       outcome;
        logic [MV_W-1:0]  battery_millivolts;
        logic [PCT_W-1:0] charge_percent;
        logic             is_low;
        logic             is_charging;
        logic             is_full;
    } t_bg_out;

    typedef struct packed {
        logic               start;
        logic [NBITS_W-1:0] nbits;
        logic [DIV_W-1:0]   dividend;
        logic [OHM_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/battery_gauge_trimmed_mean_soc.sv
// Top level of the trimmed-mean battery gauge with state-of-charge lookup.
//
// Input channel i_valid/o_ready carries one ADC sample per transaction; output
// channel o_valid/i_ready carries one result per transaction. Configuration is
// written through i_cfg_we, i_cfg_index and i_cfg_data, one register a cycle.
// A good sample that does not complete a batch is taken and gives no result.
// A failed sample's result is loaded into the output register from S_EMIT once
// that register is free. The sample that completes a batch starts a sequence on
// one shared bit-serial divider (one quotient bit per cycle) and a bit-serial
// multiplier: the trimmed-mean division, the multiply, the scale division (not
// for a zero bottom resistor) and the curve division (not for voltages out of
// range or off the curve ends); input stays closed until its result is loaded.
// The result sits in an output register until taken; a new sample is taken
// while it waits, but a following result waits for that register to empty.
// Synchronous active-low reset clears the batch, the held reading and the
// output register and loads the register reset values.
module battery_gauge_trimmed_mean_soc #(
    parameter int SAMPLES_PER_READING = bgtm_pkg::SAMPLES_PER_READING_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bgtm_pkg::t_bg_in                   i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output bgtm_pkg::t_bg_out                  o_data,
    input  logic                               i_cfg_we,
    input  logic [bgtm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgtm_pkg::CFG_W-1:0]         i_cfg_data
);
    import bgtm_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_READING);
    localparam int SUM_W = $clog2(SAMPLES_PER_READING * (2 ** SAMPLE_BITS - 1) + 1);
    localparam int MCNT_W = $clog2(SAMPLE_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_AVG_GO, S_AVG_WAIT, S_MUL, S_SCALE_GO, S_SCALE_WAIT,
        S_CHECK, S_CURVE_GO, S_CURVE_WAIT, S_FINISH, S_EMIT
    } t_state;

    t_state r_state;
    logic [OHM_W-1:0] r_top, r_bot;
    logic [MV_W-1:0]  r_min, r_max, r_full_mv;
    logic [PCT_W-1:0] r_low_pct;
    logic [1:0]       r_pins;
    logic             r_level;

    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic                   r_chg, r_full;
    logic [SUMS_W-1:0]      r_s;
    logic [DIV_W-1:0]       r_prod;
    logic [MCNT_W-1:0]      r_mcnt;
    logic [MV_W-1:0]        r_mv;
    logic [PCT_W-1:0]       r_pct;
    logic [PCT_W-1:0]       r_p0;
    logic [OHM_W-1:0]       r_dm;
    logic [CURVE_X_W-1:0]   r_x;
    t_bg_out                r_res;

    logic                   r_held_present;
    logic [MV_W-1:0]        r_held_mv;
    logic [PCT_W-1:0]       r_held_pct;
    logic [2:0]             r_held_flags;

    logic    r_out_valid;
    t_bg_out r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [SAMPLE_BITS-1:0] smp;
    logic [SUM_W-1:0]       trim;
    logic [SUMS_W:0]        madd;
    logic                   in_fire;
    logic [3:0]             seg;
    logic [MV_W-1:0]        seg_off;
    logic [PCT_W-1:0]       dp;
    logic                   is_low, is_chg, is_full;

    bgtm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign smp = i_data.sample_millivolts;
    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data = r_out;
    assign trim = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);
    assign madd = {1'b0, r_prod[DIV_W-1:SAMPLE_BITS]} + (r_prod[0] ? {1'b0, r_s} : '0);

    always_comb begin
        seg = 4'd8;
        for (int k = 7; k >= 1; k--) begin
            if (r_mv <= CURVE_MV[k]) begin
                seg = 4'(k);
            end
        end
        seg_off = r_mv - CURVE_MV[seg - 4'd1];
        dp = CURVE_PCT[seg] - CURVE_PCT[seg - 4'd1];
    end

    assign is_low = (r_pct <= r_low_pct);
    assign is_chg = r_pins[0] && (r_chg == r_level);
    assign is_full = r_pins[1] ? (r_full == r_level) : (r_mv >= r_full_mv);

    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_AVG_GO: begin
                div_req.start = 1'b1;
                div_req.nbits = NBITS_W'(SUM_W);
                div_req.dividend = {trim, {(DIV_W - SUM_W){1'b0}}};
                div_req.divisor = OHM_W'(SAMPLES_PER_READING - 2);
            end
            S_SCALE_GO: begin
                div_req.start = 1'b1;
                div_req.nbits = NBITS_W'(DIV_W);
                div_req.dividend = r_prod;
                div_req.divisor = r_bot;
            end
            S_CURVE_GO: begin
                div_req.start = 1'b1;
                div_req.nbits = NBITS_W'(CURVE_X_W);
                div_req.dividend = {r_x, {(DIV_W - CURVE_X_W){1'b0}}};
                div_req.divisor = r_dm;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= OHM_W'(100000);
            r_bot <= OHM_W'(100000);
            r_min <= MV_W'(2500);
            r_max <= MV_W'(4500);
            r_low_pct <= PCT_W'(20);
            r_full_mv <= MV_W'(4150);
            r_pins <= 2'd0;
            r_level <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOP:     r_top <= i_cfg_data[OHM_W-1:0];
                CFG_BOTTOM:  r_bot <= i_cfg_data[OHM_W-1:0];
                CFG_MIN_MV:  r_min <= i_cfg_data[MV_W-1:0];
                CFG_MAX_MV:  r_max <= i_cfg_data[MV_W-1:0];
                CFG_LOW_PCT: r_low_pct <= i_cfg_data[PCT_W-1:0];
                CFG_FULL_MV: r_full_mv <= i_cfg_data[MV_W-1:0];
                CFG_PINS:    r_pins <= i_cfg_data[1:0];
                CFG_LEVEL:   r_level <= i_cfg_data[0];
                default:     r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_held_present <= 1'b0;
            r_held_mv <= '0;
            r_held_pct <= '0;
            r_held_flags <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_data.sample_failed) begin
                            r_cnt <= '0;
                            r_res <= '{has_reading: 1'b0, outcome: OUT_FAILED, default: '0};
                            r_state <= S_EMIT;
                        end else begin
                            if (r_cnt == '0) begin
                                r_sum <= SUM_W'(smp);
                                r_lo <= smp;
                                r_hi <= smp;
                            end else begin
                                r_sum <= r_sum + SUM_W'(smp);
                                if (smp < r_lo) r_lo <= smp;
                                if (smp > r_hi) r_hi <= smp;
                            end
                            if (r_cnt == CNT_W'(SAMPLES_PER_READING - 1)) begin
                                r_cnt <= '0;
                                r_chg <= i_data.charge_pin_level;
                                r_full <= i_data.full_pin_level;
                                r_state <= S_AVG_GO;
                            end else begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                    end
                end
                S_AVG_GO: r_state <= S_AVG_WAIT;
                S_AVG_WAIT: begin
                    if (div_rsp.done) begin
                        r_prod <= {{SUMS_W{1'b0}}, div_rsp.quotient[SAMPLE_BITS-1:0]};
                        r_s <= {1'b0, r_top} + {1'b0, r_bot};
                        r_mcnt <= MCNT_W'(SAMPLE_BITS);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= {madd, r_prod[SAMPLE_BITS-1:1]};
                    r_mcnt <= r_mcnt - 1'b1;
                    if (r_mcnt == MCNT_W'(1)) begin
                        if (r_bot == '0) begin
                            r_mv <= '1;
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_SCALE_GO;
                        end
                    end
                end
                S_SCALE_GO: r_state <= S_SCALE_WAIT;
                S_SCALE_WAIT: begin
                    if (div_rsp.done) begin
                        r_mv <= (div_rsp.quotient[DIV_W-1:MV_W] != '0) ? '1 :
                                div_rsp.quotient[MV_W-1:0];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_mv < r_min || r_mv > r_max) begin
                        if (r_held_present) begin
                            r_res <= '{has_reading: 1'b1, outcome: OUT_HELD,
                                       battery_millivolts: r_held_mv,
                                       charge_percent: r_held_pct,
                                       is_low: r_held_flags[0],
                                       is_charging: r_held_flags[1],
                                       is_full: r_held_flags[2]};
                        end else begin
                            r_res <= '{has_reading: 1'b0, outcome: OUT_NONE, default: '0};
                        end
                        r_state <= S_EMIT;
                    end else if (r_mv <= CURVE_MV[0]) begin
                        r_pct <= CURVE_PCT[0];
                        r_state <= S_FINISH;
                    end else if (r_mv > CURVE_MV[8]) begin
                        r_pct <= CURVE_PCT[8];
                        r_state <= S_FINISH;
                    end else begin
                        r_p0 <= CURVE_PCT[seg - 4'd1];
                        r_dm <= OHM_W'(CURVE_MV[seg] - CURVE_MV[seg - 4'd1]);
                        r_x <= CURVE_X_W'(seg_off[7:0]) * CURVE_X_W'(dp[4:0]);
                        r_state <= S_CURVE_GO;
                    end
                end
                S_CURVE_GO: r_state <= S_CURVE_WAIT;
                S_CURVE_WAIT: begin
                    if (div_rsp.done) begin
                        r_pct <= r_p0 + div_rsp.quotient[PCT_W-1:0];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_held_present <= 1'b1;
                    r_held_mv <= r_mv;
                    r_held_pct <= r_pct;
                    r_held_flags <= {is_full, is_chg, is_low};
                    r_res <= '{has_reading: 1'b1, outcome: OUT_NEW,
                               battery_millivolts: r_mv, charge_percent: r_pct,
                               is_low: is_low, is_charging: is_chg, is_full: is_full};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out <= r_res;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_data.sample_failed) |=> (r_cnt == '0))
        else $error("failed sample did not clear the batch");
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.charge_percent <= PCT_W'(100)))
        else $error("charge percent above 100");
    a_no_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.has_reading) |->
        (o_data.outcome == OUT_NONE || o_data.outcome == OUT_FAILED))
        else $error("result without reading has wrong outcome");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider finished right after start");
`endif

endmodule

>>> hw/rtl/bgtm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module bgtm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgtm_pkg::t_div_req i_req,
    output bgtm_pkg::t_div_rsp o_rsp
);
    import bgtm_pkg::*;

    logic [OHM_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_q;
    logic [OHM_W-1:0]   r_div;
    logic [NBITS_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [OHM_W:0]     rem_sh;
    logic [OHM_W+1:0]   diff;
    logic               ge;

    assign rem_sh = {r_rem, r_q[DIV_W-1]};
    assign diff = {1'b0, rem_sh} - {2'b00, r_div};
    assign ge = !diff[OHM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NBITS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[OHM_W-1:0] : rem_sh[OHM_W-1:0];
            r_q <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_q;

endmodule
